// ===== design/npc_pkg.sv =====
`timescale 1ns / 1ps

package npc_pkg;

    // Default palette depth and field widths.
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int ENTRY_W             = 18;
    localparam int DIST_W              = 18;
    localparam int QUEUE_DEPTH         = 2;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_INDEX = 1'b1;
    localparam logic [7:0] ALPHA_THRESHOLD_RST   = 8'd128;
    localparam logic [7:0] TRANSPARENT_INDEX_RST = 8'd255;

    // Action codes carried in the input word.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Starting value of the running minimum; above any real distance.
    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    typedef struct packed {
        logic       action;
        logic [7:0] entry_index;
        logic [5:0] entry_red;
        logic [5:0] entry_green;
        logic [5:0] entry_blue;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
    } t_in_word;

    typedef struct packed {
        logic [7:0]        color_index;
        logic              is_transparent;
        logic [DIST_W-1:0] best_distance;
    } t_out_word;

    // Job kinds decided by the front end.
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_CLEAR,
        KIND_SCAN
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_word word;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_EMIT
    } t_back_state;

    // Palette entries are stored as red, green, blue from the top down.
    function automatic logic [ENTRY_W-1:0] pack_entry(input logic [5:0] red,
                                                      input logic [5:0] green,
                                                      input logic [5:0] blue);
        return {red, green, blue};
    endfunction

    // Square of the absolute difference of two 8-bit components.
    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

endpackage

// ===== design/npc_ram.sv =====
`timescale 1ns / 1ps

module npc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/npc_front.sv =====
`timescale 1ns / 1ps

module npc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  npc_pkg::t_in_word i_in_word,
    input  logic [7:0]        i_alpha_threshold,
    output logic              o_job_valid,
    output npc_pkg::t_job     o_job,
    input  logic              i_job_pop
);

    localparam int QAW = (npc_pkg::QUEUE_DEPTH > 1) ? $clog2(npc_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(npc_pkg::QUEUE_DEPTH + 1);

    npc_pkg::t_job  r_q [npc_pkg::QUEUE_DEPTH];
    npc_pkg::t_job  in_job;
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           push;
    logic           pop;

    // Classify each word as a palette write, a transparent pixel or a full scan.
    always_comb begin
        in_job.word = i_in_word;
        priority if (i_in_word.action == npc_pkg::ACT_WRITE) begin
            in_job.kind = npc_pkg::KIND_WRITE;
        end else if (i_in_word.pixel_alpha < i_alpha_threshold) begin
            in_job.kind = npc_pkg::KIND_CLEAR;
        end else begin
            in_job.kind = npc_pkg::KIND_SCAN;
        end
    end

    assign o_in_stall  = (r_count == QCW'(npc_pkg::QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_job_pop && o_job_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_job;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(npc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(npc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(npc_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    // A push without a pop grows the queue by exactly one word.
    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

// ===== design/npc_back.sv =====
`timescale 1ns / 1ps

module npc_back #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  npc_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  logic [7:0]         i_transparent_index,
    output logic               o_out_valid,
    output npc_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

    npc_pkg::t_back_state       r_state;
    npc_pkg::t_back_state       n_state;
    logic [AW-1:0]              r_addr;
    logic [7:0]                 r_pix_red;
    logic [7:0]                 r_pix_green;
    logic [7:0]                 r_pix_blue;
    logic                       r_s1_vld;
    logic                       r_s1_last;
    logic [AW-1:0]              r_s1_idx;
    logic                       r_s2_vld;
    logic                       r_s2_last;
    logic [AW-1:0]              r_s2_idx;
    logic [15:0]                r_sq_red;
    logic [15:0]                r_sq_green;
    logic [15:0]                r_sq_blue;
    logic [npc_pkg::DIST_W-1:0] r_best_dist;
    logic [AW-1:0]              r_best_idx;
    logic [npc_pkg::DIST_W-1:0] cand_dist;
    logic                       r_out_valid;
    npc_pkg::t_out_word         r_out_word;
    logic [npc_pkg::ENTRY_W-1:0] ram_rdata;
    logic                       ram_we;
    logic                       in_range;
    logic                       out_free;
    logic                       issue;
    logic                       start;
    logic                       load_clear;
    logic                       load_scan;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = ({1'b0, i_job.word.entry_index} < 9'(PALETTE_ENTRIES));

    // Palette memory: written by write jobs, swept once per scan.
    npc_ram #(
        .WIDTH (npc_pkg::ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_job.word.entry_index[AW-1:0]),
        .i_wdata (npc_pkg::pack_entry(i_job.word.entry_red, i_job.word.entry_green,
                                      i_job.word.entry_blue)),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Job sequencer: next state and control strobes.
    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        ram_we     = 1'b0;
        issue      = 1'b0;
        start      = 1'b0;
        load_clear = 1'b0;
        load_scan  = 1'b0;
        unique case (r_state)
            npc_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.kind)
                        npc_pkg::KIND_WRITE: begin
                            o_job_pop = 1'b1;
                            ram_we    = in_range;
                        end
                        npc_pkg::KIND_CLEAR: begin
                            if (out_free) begin
                                o_job_pop  = 1'b1;
                                load_clear = 1'b1;
                            end
                        end
                        npc_pkg::KIND_SCAN: begin
                            o_job_pop = 1'b1;
                            start     = 1'b1;
                            n_state   = npc_pkg::BK_SCAN;
                        end
                        default: begin
                            o_job_pop = 1'b1;
                        end
                    endcase
                end
            end
            npc_pkg::BK_SCAN: begin
                issue = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = npc_pkg::BK_DRAIN;
                end
            end
            npc_pkg::BK_DRAIN: begin
                if (r_s2_vld && r_s2_last) begin
                    n_state = npc_pkg::BK_EMIT;
                end
            end
            npc_pkg::BK_EMIT: begin
                if (out_free) begin
                    load_scan = 1'b1;
                    n_state   = npc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = npc_pkg::BK_IDLE;
            end
        endcase
    end

    // Candidate distance from the registered squares.
    assign cand_dist = npc_pkg::DIST_W'(r_sq_red) + npc_pkg::DIST_W'(r_sq_green)
                     + npc_pkg::DIST_W'(r_sq_blue);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npc_pkg::BK_IDLE;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (load_clear || load_scan) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan address, pixel latch and distance pipeline.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_addr      <= '0;
            r_pix_red   <= i_job.word.pixel_red;
            r_pix_green <= i_job.word.pixel_green;
            r_pix_blue  <= i_job.word.pixel_blue;
            r_best_dist <= npc_pkg::DIST_INIT;
            r_best_idx  <= '0;
        end else begin
            if (issue && (r_addr != LAST_ADDR)) begin
                r_addr <= r_addr + 1'b1;
            end
            // Strict compare keeps the lowest index on ties.
            if (r_s2_vld && (cand_dist < r_best_dist)) begin
                r_best_dist <= cand_dist;
                r_best_idx  <= r_s2_idx;
            end
        end
        r_s1_idx   <= r_addr;
        r_s1_last  <= (r_addr == LAST_ADDR);
        r_s2_idx   <= r_s1_idx;
        r_s2_last  <= r_s1_last;
        r_sq_red   <= npc_pkg::sq_diff(r_pix_red,   {ram_rdata[17:12], 2'b00});
        r_sq_green <= npc_pkg::sq_diff(r_pix_green, {ram_rdata[11:6],  2'b00});
        r_sq_blue  <= npc_pkg::sq_diff(r_pix_blue,  {ram_rdata[5:0],   2'b00});
    end

    // Result register; holds while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (load_clear) begin
            r_out_word.color_index    <= i_transparent_index;
            r_out_word.is_transparent <= 1'b1;
            r_out_word.best_distance  <= '0;
        end else if (load_scan) begin
            r_out_word.color_index    <= 8'(r_best_idx);
            r_out_word.is_transparent <= 1'b0;
            r_out_word.best_distance  <= r_best_dist;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A job leaves the queue only when one is there.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> i_job_valid)
        else $error("job popped from an empty queue");

    // Distance samples only flow while a scan is in progress.
    a_s2_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_state == npc_pkg::BK_SCAN || r_state == npc_pkg::BK_DRAIN))
        else $error("distance sample outside a scan");

    // A transparent result always reports zero distance.
    a_clear_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.is_transparent) |-> (r_out_word.best_distance == '0))
        else $error("transparent result with nonzero distance");

endmodule

// ===== design/nearest_palette_color.sv =====
`timescale 1ns / 1ps

// Nearest palette color: a write word (action 0) loads one palette slot in the back end;
// a slot at or above PALETTE_ENTRIES is dropped. A pixel word (action 1) whose alpha is
// below the threshold returns the transparent index without a scan. Any other pixel
// sweeps the whole palette through the single read port of the palette RAM, one entry
// per cycle, then drains the distance pipeline and loads its result into the result
// register. A two-word input queue keeps accepting words while a scan runs until it is
// full, and the result register holds a finished word while the consumer stalls.
// Every palette slot must be written before the first opaque pixel is sent.

module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  npc_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output npc_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_we,
    input  logic [npc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    logic [7:0]    r_alpha_threshold;
    logic [7:0]    r_transparent_index;
    logic          job_valid;
    npc_pkg::t_job job;
    logic          job_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_threshold   <= npc_pkg::ALPHA_THRESHOLD_RST;
            r_transparent_index <= npc_pkg::TRANSPARENT_INDEX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                npc_pkg::CFG_ALPHA_THRESHOLD:   r_alpha_threshold   <= i_cfg_data;
                npc_pkg::CFG_TRANSPARENT_INDEX: r_transparent_index <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: input queue and classification.
    npc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_word         (i_in_word),
        .i_alpha_threshold (r_alpha_threshold),
        .o_job_valid       (job_valid),
        .o_job             (job),
        .i_job_pop         (job_pop)
    );

    // Back end: palette store, scan engine and result register.
    npc_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_job_valid         (job_valid),
        .i_job               (job),
        .o_job_pop           (job_pop),
        .i_transparent_index (r_transparent_index),
        .o_out_valid         (o_out_valid),
        .o_out_word          (o_out_word),
        .i_out_stall         (i_out_stall)
    );

endmodule
